// File: design/foes_pkg.sv
// Package for the frame ordered event scheduler: word types, command and
// status codes, default sizes. No dependencies.
package foes_pkg;

    localparam int FRAME_W   = 22;
    localparam int CAPACITY  = 32;
    localparam int MAX_OUT   = 32;
    localparam int NOUT_W    = $clog2(MAX_OUT + 1);

    localparam logic [1:0] CMD_SCHEDULE = 2'd0;
    localparam logic [1:0] CMD_EXECUTE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;

    localparam logic [2:0] ST_DUE       = 3'd0;
    localparam logic [2:0] ST_SCHEDULED = 3'd1;
    localparam logic [2:0] ST_DROPPED   = 3'd2;
    localparam logic [2:0] ST_NOTHING   = 3'd3;
    localparam logic [2:0] ST_CLEARED   = 3'd4;

    typedef struct packed {
        logic [1:0]         command;
        logic [FRAME_W-1:0] frame_number;
        logic [2:0]         timeslot;
        logic [15:0]        message_handle;
        logic [3:0]         handler_id;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic [FRAME_W-1:0] event_frame;
        logic [2:0]         event_timeslot;
        logic [15:0]        event_message;
        logic [3:0]         event_handler;
        logic               last;
    } t_out;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [2:0]         slot;
        logic [15:0]        msg;
        logic [3:0]         handler;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// File: design/foes_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies.
module foes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

// File: design/frame_ordered_event_scheduler_top.sv
// Frame ordered event scheduler: sorted event store in one RAM, walked by a
// small sequencer. Depends on foes_pkg and foes_ram.
//
// Usage:
//   A command word is taken at a rising edge with start high and busy low.
//   Results leave on o_out, one word per cycle in which o_strobe is high;
//   the receiver cannot stall, every strobed word is taken. The final word
//   of a command has last set. Command 3 gives no word.
// Command flow:
//   clear, full schedule: one word the cycle after acceptance; busy stays low.
//   schedule: the insert walks back from the tail, a read (SRD) and a
//     shift (SEV) per entry shifted; the word comes out as busy falls.
//   execute: every entry is read and either emitted or compacted, a read
//     (XRD) and an evaluate (XEV) step per entry through the single RAM
//     read port, then a closing XRD. Due words come out during the walk, the
//     last one (or a nothing due word) at its end.
// Reset clears the entry count, the last executed frame and the sequencer;
// the RAM contents need no reset.
module frame_ordered_event_scheduler_top #(
    parameter int CAPACITY = foes_pkg::CAPACITY
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  foes_pkg::t_in   i_in,
    output logic            busy,
    output logic            o_strobe,
    output foes_pkg::t_out  o_out
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int NW = foes_pkg::NOUT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRD  = 3'd1;
    localparam logic [2:0] S_SEV  = 3'd2;
    localparam logic [2:0] S_XRD  = 3'd3;
    localparam logic [2:0] S_XEV  = 3'd4;

    logic [2:0]                    r_state, n_state;
    logic [CW-1:0]                 r_cnt, n_cnt;
    logic [CW-1:0]                 r_idx, n_idx;
    logic [CW-1:0]                 r_keep, n_keep;
    logic [NW-1:0]                 r_nout, n_nout;
    logic [foes_pkg::FRAME_W-1:0]  r_last_fr, n_last_fr;
    logic [foes_pkg::FRAME_W-1:0]  r_now, n_now;
    logic                          r_wrap, n_wrap;
    foes_pkg::t_entry              r_new, n_new;
    foes_pkg::t_entry              r_pend, n_pend;
    logic                          r_pend_v, n_pend_v;
    logic                          r_strobe, n_strobe;
    foes_pkg::t_out                r_out, n_out;

    logic                          we;
    logic [AW-1:0]                 waddr, raddr;
    foes_pkg::t_entry              wdata, q;
    logic [foes_pkg::ENTRY_W-1:0]  q_raw;
    logic [CW-1:0]                 idx_m1;
    logic                          due;

    assign idx_m1 = r_idx - CW'(1);
    assign raddr  = (r_state == S_SRD) ? idx_m1[AW-1:0] : r_idx[AW-1:0];
    assign q      = foes_pkg::t_entry'(q_raw);
    assign due    = (q.frame <= r_now) || (r_wrap && (q.frame > r_last_fr));

    foes_ram #(
        .WIDTH (foes_pkg::ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (q_raw)
    );

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_keep    = r_keep;
        n_nout    = r_nout;
        n_last_fr = r_last_fr;
        n_now     = r_now;
        n_wrap    = r_wrap;
        n_new     = r_new;
        n_pend    = r_pend;
        n_pend_v  = r_pend_v;
        n_strobe  = 1'b0;
        n_out     = '0;
        n_out.last = 1'b1;
        we        = 1'b0;
        waddr     = r_idx[AW-1:0];
        wdata     = r_new;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_in.command)
                        foes_pkg::CMD_SCHEDULE: begin
                            if (r_cnt == CW'(CAPACITY)) begin
                                n_strobe     = 1'b1;
                                n_out.status = foes_pkg::ST_DROPPED;
                            end else begin
                                n_new.frame   = i_in.frame_number;
                                n_new.slot    = i_in.timeslot;
                                n_new.msg     = i_in.message_handle;
                                n_new.handler = i_in.handler_id;
                                n_idx         = r_cnt;
                                n_state       = S_SRD;
                            end
                        end
                        foes_pkg::CMD_EXECUTE: begin
                            n_now    = i_in.frame_number;
                            n_wrap   = i_in.frame_number < r_last_fr;
                            n_idx    = '0;
                            n_keep   = '0;
                            n_nout   = '0;
                            n_pend_v = 1'b0;
                            n_state  = S_XRD;
                        end
                        foes_pkg::CMD_CLEAR: begin
                            n_cnt        = '0;
                            n_strobe     = 1'b1;
                            n_out.status = foes_pkg::ST_CLEARED;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SRD: begin
                if (r_idx == '0) begin
                    we           = 1'b1;
                    n_cnt        = r_cnt + CW'(1);
                    n_strobe     = 1'b1;
                    n_out.status = foes_pkg::ST_SCHEDULED;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_SEV;
                end
            end
            S_SEV: begin
                we = 1'b1;
                if (q.frame <= r_new.frame) begin
                    n_cnt        = r_cnt + CW'(1);
                    n_strobe     = 1'b1;
                    n_out.status = foes_pkg::ST_SCHEDULED;
                    n_state      = S_IDLE;
                end else begin
                    wdata   = q;
                    n_idx   = idx_m1;
                    n_state = S_SRD;
                end
            end
            S_XRD: begin
                if (r_idx == r_cnt) begin
                    n_cnt     = r_keep;
                    n_last_fr = r_now;
                    n_strobe  = 1'b1;
                    n_state   = S_IDLE;
                    if (r_pend_v) begin
                        n_out.status         = foes_pkg::ST_DUE;
                        n_out.event_frame    = r_pend.frame;
                        n_out.event_timeslot = r_pend.slot;
                        n_out.event_message  = r_pend.msg;
                        n_out.event_handler  = r_pend.handler;
                    end else begin
                        n_out.status = foes_pkg::ST_NOTHING;
                    end
                end else begin
                    n_state = S_XEV;
                end
            end
            S_XEV: begin
                if (due && (r_nout < NW'(foes_pkg::MAX_OUT))) begin
                    if (r_pend_v) begin
                        n_strobe             = 1'b1;
                        n_out.status         = foes_pkg::ST_DUE;
                        n_out.event_frame    = r_pend.frame;
                        n_out.event_timeslot = r_pend.slot;
                        n_out.event_message  = r_pend.msg;
                        n_out.event_handler  = r_pend.handler;
                        n_out.last           = 1'b0;
                    end
                    n_pend   = q;
                    n_pend_v = 1'b1;
                    n_nout   = r_nout + NW'(1);
                end else begin
                    we     = 1'b1;
                    waddr  = r_keep[AW-1:0];
                    wdata  = q;
                    n_keep = r_keep + CW'(1);
                end
                n_idx   = r_idx + CW'(1);
                n_state = S_XRD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_last_fr <= '0;
            r_strobe  <= 1'b0;
            r_pend_v  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_last_fr <= n_last_fr;
            r_strobe  <= n_strobe;
            r_pend_v  <= n_pend_v;
        end
        r_idx  <= n_idx;
        r_keep <= n_keep;
        r_nout <= n_nout;
        r_now  <= n_now;
        r_wrap <= n_wrap;
        r_new  <= n_new;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_out    = r_out;
endmodule

// File: bench/frame_ordered_event_scheduler_top_test.sv
// Self-checking bench for frame_ordered_event_scheduler_top: directed and random
// command words, each result word checked against an in-bench model of the store.
// Depends on foes_pkg and the design files.
module frame_ordered_event_scheduler_top_test;
    import foes_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [FRAME_W-1:0] FRAME_TOP = 22'd2715647;
    localparam logic [FRAME_W-1:0] FRAME_ALL = '1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_in i_in = '0;
    logic busy;
    logic o_strobe;
    t_out o_out;

    t_entry pending_events[$];
    logic [FRAME_W-1:0] last_exec_frame = '0;
    t_out scheduler_answers[$];
    t_out oldest_answer;
    logic [FRAME_W-1:0] now_frame = '0;
    int mismatches = 0;
    int cycles = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;

    frame_ordered_event_scheduler_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_in     (i_in),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_out    (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic void note_mismatch(string what, t_out want, t_out got);
        if (mismatches < 10) begin
            $display("mismatch, %s: expected st=%0d fr=%0d ts=%0d msg=%h hd=%0d last=%b",
                     what, want.status, want.event_frame, want.event_timeslot,
                     want.event_message, want.event_handler, want.last);
            $display("    got st=%0d fr=%0d ts=%0d msg=%h hd=%0d last=%b",
                     got.status, got.event_frame, got.event_timeslot,
                     got.event_message, got.event_handler, got.last);
        end
        mismatches++;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (scheduler_answers.size() == 0) begin
                note_mismatch("no word due", '0, o_out);
            end else begin
                oldest_answer = scheduler_answers.pop_front();
                if (oldest_answer.status !== o_out.status
                        || oldest_answer.event_frame !== o_out.event_frame
                        || oldest_answer.event_timeslot !== o_out.event_timeslot
                        || oldest_answer.event_message !== o_out.event_message
                        || oldest_answer.event_handler !== o_out.event_handler
                        || oldest_answer.last !== o_out.last) begin
                    note_mismatch("field", oldest_answer, o_out);
                end
            end
        end
    end

    function automatic bit entry_due(logic [FRAME_W-1:0] frame, logic [FRAME_W-1:0] now,
                                     bit wrapped);
        return frame <= now || (wrapped && frame > last_exec_frame);
    endfunction

    function automatic t_out event_word(t_entry e, bit is_last);
        t_out r;
        r = '0;
        r.status = ST_DUE;
        r.event_frame = e.frame;
        r.event_timeslot = e.slot;
        r.event_message = e.msg;
        r.event_handler = e.handler;
        r.last = is_last;
        return r;
    endfunction

    task automatic apply_command(input t_in w);
        t_entry e;
        t_entry kept[$];
        t_out r;
        int pos;
        int n_due;
        int n;
        bit wrapped;
        r = '0;
        r.last = 1'b1;
        case (w.command)
            CMD_SCHEDULE: begin
                if (pending_events.size() >= CAPACITY) begin
                    r.status = ST_DROPPED;
                end else begin
                    e.frame = w.frame_number;
                    e.slot = w.timeslot;
                    e.msg = w.message_handle;
                    e.handler = w.handler_id;
                    pos = 0;
                    while (pos < pending_events.size() && pending_events[pos].frame <= e.frame)
                        pos++;
                    pending_events.insert(pos, e);
                    r.status = ST_SCHEDULED;
                end
                scheduler_answers.push_back(r);
            end
            CMD_EXECUTE: begin
                wrapped = w.frame_number < last_exec_frame;
                n_due = 0;
                foreach (pending_events[i])
                    if (entry_due(pending_events[i].frame, w.frame_number, wrapped))
                        n_due++;
                if (n_due > MAX_OUT)
                    n_due = MAX_OUT;
                n = 0;
                foreach (pending_events[i]) begin
                    if (n < n_due && entry_due(pending_events[i].frame, w.frame_number, wrapped)) begin
                        scheduler_answers.push_back(event_word(pending_events[i], n == n_due - 1));
                        n++;
                    end else begin
                        kept.push_back(pending_events[i]);
                    end
                end
                pending_events = kept;
                last_exec_frame = w.frame_number;
                if (n_due == 0) begin
                    r.status = ST_NOTHING;
                    scheduler_answers.push_back(r);
                end
            end
            CMD_CLEAR: begin
                pending_events.delete();
                r.status = ST_CLEARED;
                scheduler_answers.push_back(r);
            end
            default: ;
        endcase
    endtask

    function automatic t_in noise_word();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(t_in)-1:0];
    endfunction

    function automatic t_in make_word(logic [1:0] cmd, logic [FRAME_W-1:0] frame,
                                      logic [2:0] slot, logic [15:0] msg, logic [3:0] hd);
        t_in w;
        w.command = cmd;
        w.frame_number = frame;
        w.timeslot = slot;
        w.message_handle = msg;
        w.handler_id = hd;
        return w;
    endfunction

    function automatic t_in schedule_word(logic [FRAME_W-1:0] frame);
        return make_word(CMD_SCHEDULE, frame, 3'($urandom), 16'($urandom), 4'($urandom));
    endfunction

    function automatic t_in execute_word(logic [FRAME_W-1:0] frame);
        t_in w;
        w = noise_word();
        w.command = CMD_EXECUTE;
        w.frame_number = frame;
        return w;
    endfunction

    task automatic send_word(input t_in w);
        int gap;
        start <= 1'b1;
        i_in <= w;
        do @(posedge i_clk); while (busy);
        apply_command(w);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            if (gaps_on) begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 12);
                start <= 1'b0;
                i_in <= noise_word();
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic test_basic_ops();
        send_word(execute_word('0));
        send_word(make_word(CMD_SCHEDULE, 22'd5, 3'd0, 16'h0000, 4'h0));
        send_word(make_word(CMD_SCHEDULE, 22'd0, 3'd7, 16'hFFFF, 4'hF));
        send_word(make_word(CMD_SCHEDULE, FRAME_TOP, 3'd3, 16'hA5A5, 4'h5));
        send_word(make_word(CMD_SCHEDULE, 22'd5, 3'd4, 16'h5A5A, 4'hA));
        send_word(execute_word(22'd5));
        // hyperframe wrap: frames above the last executed one fire
        send_word(execute_word(22'd4));
        send_word(make_word(CMD_UNUSED, FRAME_ALL, 3'd7, 16'hFFFF, 4'hF));
        send_word(schedule_word(22'd3));
        send_word(make_word(CMD_CLEAR, FRAME_ALL, 3'd7, 16'hFFFF, 4'hF));
        send_word(execute_word(FRAME_ALL));
    endtask

    task automatic test_same_frame_order();
        send_word(make_word(CMD_SCHEDULE, 22'd100, 3'd1, 16'h0100, 4'd1));
        send_word(make_word(CMD_SCHEDULE, 22'd101, 3'd2, 16'h0101, 4'd2));
        send_word(make_word(CMD_SCHEDULE, 22'd100, 3'd3, 16'h0102, 4'd3));
        send_word(make_word(CMD_SCHEDULE, 22'd99, 3'd4, 16'h0099, 4'd4));
        send_word(make_word(CMD_SCHEDULE, 22'd100, 3'd5, 16'h0103, 4'd5));
        send_word(make_word(CMD_SCHEDULE, 22'd100, 3'd6, 16'h0104, 4'd6));
        send_word(execute_word(22'd100));
        send_word(execute_word(22'd101));
    endtask

    task automatic test_frame_extremes();
        send_word(schedule_word(FRAME_ALL));
        send_word(schedule_word(22'h155555));
        send_word(schedule_word(22'h2AAAAA));
        send_word(execute_word(FRAME_TOP));
        send_word(execute_word(FRAME_ALL));
        send_word(execute_word('0));
    endtask

    task automatic test_fill_and_drain(input int rounds);
        for (int k = 0; k < rounds; k++) begin
            while (pending_events.size() < CAPACITY)
                send_word(schedule_word(now_frame + FRAME_W'($urandom_range(0, 15))));
            send_word(schedule_word(22'($urandom)));
            send_word(schedule_word(22'($urandom)));
            if (k == 0) begin
                send_word(execute_word(FRAME_ALL));
            end else begin
                send_word(execute_word(now_frame + FRAME_W'(7)));
                send_word(execute_word(FRAME_ALL));
            end
            now_frame = FRAME_W'($urandom_range(0, 40));
        end
    endtask

    task automatic test_random(input int count);
        int pick;
        for (int k = 0; k < count; k++) begin
            gaps_on = !(k >= count / 3 && k < count / 2);
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_word(schedule_word(now_frame + FRAME_W'($urandom_range(0, 30))));
            end else if (pick < 62) begin
                send_word(schedule_word(22'($urandom)));
            end else if (pick < 90) begin
                if ($urandom_range(0, 9) == 0)
                    now_frame = FRAME_W'($urandom_range(0, 40));
                else
                    now_frame = now_frame + FRAME_W'($urandom_range(0, 12));
                send_word(execute_word(now_frame));
            end else if (pick < 95) begin
                send_word(execute_word(22'($urandom)));
            end else if (pick < 97) begin
                send_word(make_word(CMD_CLEAR, 22'($urandom), 3'($urandom), 16'($urandom),
                                    4'($urandom)));
            end else begin
                send_word(make_word(CMD_UNUSED, 22'($urandom), 3'($urandom), 16'($urandom),
                                    4'($urandom)));
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_ops();
        test_same_frame_order();
        test_frame_extremes();
        test_fill_and_drain(2);
        now_frame = FRAME_W'($urandom_range(1000, 2000000));
        test_random(260);
        start <= 1'b0;
        while (scheduler_answers.size() != 0)
            @(posedge i_clk);
        repeat (2 * CAPACITY + 8) @(posedge i_clk);
        if (mismatches == 0 && scheduler_answers.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
